[rtl/utf8_to_ucs2_line_splitter_defines.svh]
// Assertion macros used by the line splitter RTL.
`ifndef UTF8_TO_UCS2_LINE_SPLITTER_DEFINES_SVH
`define UTF8_TO_UCS2_LINE_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define U2LS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define U2LS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/u2ls_pkg.sv]
// Package: widths, character constants and result entry type of the line splitter.
`timescale 1ns / 1ps
`default_nettype none
package u2ls_pkg;

  localparam int DATA_W  = 8;
  localparam int LEFT_W  = 3;
  localparam int UNIT_W  = 16;
  localparam int CODE_W  = 21;
  localparam int PHASE_W = 2;

  localparam logic [UNIT_W-1:0] REPL  = 16'hFFFD;
  localparam logic [UNIT_W-1:0] CH_LF = 16'h000A;
  localparam logic [UNIT_W-1:0] CH_CR = 16'h000D;

  localparam logic KIND_UNIT = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // One result entry waiting in the output group
  typedef struct packed {
    logic              kind;
    logic [UNIT_W-1:0] code_unit;
    logic              err;
  } res_t;

endpackage
`default_nettype wire

[rtl/u2ls_if.sv]
// Stream interfaces: UTF-8 byte channel and code unit channel.
`timescale 1ns / 1ps
`default_nettype none
interface u2ls_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u2ls_pkg::DATA_W-1:0]  data_byte;
  logic [u2ls_pkg::LEFT_W-1:0]  bytes_left;

  modport source (output valid, output data_byte, output bytes_left, input ready);
  modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface u2ls_unit_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [u2ls_pkg::UNIT_W-1:0]  code_unit;
  logic                         contains_errors;
  logic                         last;

  modport source (output valid, output kind, output code_unit, output contains_errors,
                  output last, input ready);
  modport sink   (input valid, input kind, input code_unit, input contains_errors,
                  input last, output ready);
endinterface
`default_nettype wire

[rtl/utf8_to_ucs2_line_splitter.sv]
// Top level: UTF-8 byte decoder to UCS-2 code units with CR/LF line splitting.
//
//  channel  | dir | carries
//  ---------+-----+----------------------------------------------------
//  bytes    | in  | data_byte[7:0], bytes_left[2:0] (0 or 1 = final byte)
//  units    | out | kind, code_unit[15:0], contains_errors, last
//
// A byte is decoded in the cycle it is accepted; its zero to three results
// land in a result group register and leave one per cycle, while units.ready
// is high. Throughput is one byte per cycle while each byte gives at most one
// result and units.ready is high; a byte with more results holds the byte side
// until the single-entry output port has drained the group to its last result.
// rst (synchronous) clears the decoder state and empties the result group.
// bytes.ready depends on units.ready when one result is left in the group.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_ucs2_line_splitter_defines.svh"
module utf8_to_ucs2_line_splitter (
  input  wire logic  clk,
  input  wire logic  rst,
  u2ls_byte_if.sink  bytes,
  u2ls_unit_if.source units
);

  localparam int NCAND = 6;
  localparam int NSLOT = 3;

  // decoder state
  logic [u2ls_pkg::PHASE_W-1:0] phase;
  logic [u2ls_pkg::CODE_W-1:0]  partial;
  logic                         cr_held;
  logic                         error_seen;
  logic                         line_open;

  logic [u2ls_pkg::PHASE_W-1:0] phase_next;
  logic [u2ls_pkg::CODE_W-1:0]  partial_next;
  logic                         cr_held_next;
  logic                         error_seen_next;
  logic                         line_open_next;

  // result group
  u2ls_pkg::res_t slot [NSLOT];
  logic [1:0]     cnt;

  u2ls_pkg::res_t grp [NSLOT];
  logic [1:0]     grp_cnt;

  logic in_acc;
  logic out_acc;
  logic final_b;

  // byte section results
  logic                        has_unit;
  logic [u2ls_pkg::UNIT_W-1:0] unit_val;
  logic                        err1;
  logic [u2ls_pkg::PHASE_W-1:0] phase1;
  logic [u2ls_pkg::CODE_W-1:0] partial1;
  logic                        cr1;
  logic                        lo1;
  logic                        e1;
  logic                        flush_err;
  logic                        cr2;
  logic                        e2;

  logic           cand_v [NCAND];
  u2ls_pkg::res_t cand   [NCAND];

  assign in_acc  = bytes.valid && bytes.ready;
  assign out_acc = units.valid && units.ready;
  assign final_b = (bytes.bytes_left <= u2ls_pkg::LEFT_W'(1));

  assign bytes.ready = (cnt == 2'd0) || ((cnt == 2'd1) && units.ready);

  // Decode one byte against the current phase
  always_comb begin
    logic [u2ls_pkg::DATA_W-1:0] b;
    logic [u2ls_pkg::CODE_W-1:0] addend;
    b        = bytes.data_byte;
    addend   = '0;
    has_unit = 1'b0;
    unit_val = u2ls_pkg::REPL;
    err1     = 1'b0;
    phase1   = phase;
    partial1 = partial;
    if (phase == '0) begin
      if (b[7] == 1'b0) begin
        has_unit = 1'b1;
        unit_val = {8'h00, b};
      end else if (b[7:6] == 2'b10) begin
        has_unit = 1'b1;
        err1     = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        partial1 = {10'd0, b[4:0], 6'd0};
        if (bytes.bytes_left >= u2ls_pkg::LEFT_W'(2)) begin
          phase1 = 2'd1;
        end else begin
          has_unit = 1'b1;
          err1     = 1'b1;
        end
      end else if (b[7:4] == 4'b1110) begin
        partial1 = {5'd0, b[3:0], 12'd0};
        if (bytes.bytes_left >= u2ls_pkg::LEFT_W'(3)) begin
          phase1 = 2'd2;
        end else begin
          has_unit = 1'b1;
          err1     = 1'b1;
        end
      end else if (b[7:3] == 5'b11110) begin
        partial1 = {b[2:0], 18'd0};
        if (bytes.bytes_left >= u2ls_pkg::LEFT_W'(4)) begin
          phase1 = 2'd3;
        end else begin
          has_unit = 1'b1;
          err1     = 1'b1;
        end
      end else begin
        has_unit = 1'b1;
        err1     = 1'b1;
      end
    end else if (b[7:6] == 2'b10) begin
      // accumulate continuation bits at the place the phase selects
      case (phase)
        2'd1:    addend = {15'd0, b[5:0]};
        2'd2:    addend = {9'd0, b[5:0], 6'd0};
        default: addend = {3'd0, b[5:0], 12'd0};
      endcase
      partial1 = partial + addend;
      phase1   = phase - 2'd1;
      if (phase1 == '0) begin
        has_unit = 1'b1;
        unit_val = (partial1[u2ls_pkg::CODE_W-1:u2ls_pkg::UNIT_W] != '0) ?
                   u2ls_pkg::REPL : partial1[u2ls_pkg::UNIT_W-1:0];
      end
    end else begin
      phase1   = '0;
      has_unit = 1'b1;
      err1     = 1'b1;
    end
  end

  // Line and CR bookkeeping, flush on the final byte
  always_comb begin
    e1 = error_seen || err1;
    if (has_unit) begin
      cr1 = (unit_val == u2ls_pkg::CH_CR);
    end else begin
      cr1 = cr_held;
    end
    if (has_unit && (unit_val == u2ls_pkg::CH_LF)) begin
      lo1 = 1'b0;
    end else begin
      lo1 = (phase == '0) ? 1'b1 : line_open;
    end
    flush_err = final_b && (phase1 != '0);
    cr2       = flush_err ? 1'b0 : cr1;
    e2        = e1 || flush_err;

    // candidate results in emission order
    cand_v[0] = has_unit && cr_held && (unit_val != u2ls_pkg::CH_LF);
    cand[0]   = '{kind: u2ls_pkg::KIND_UNIT, code_unit: u2ls_pkg::CH_CR, err: e1};
    cand_v[1] = has_unit && (unit_val != u2ls_pkg::CH_CR);
    cand[1]   = (unit_val == u2ls_pkg::CH_LF) ?
                '{kind: u2ls_pkg::KIND_EOL, code_unit: '0, err: e1} :
                '{kind: u2ls_pkg::KIND_UNIT, code_unit: unit_val, err: e1};
    cand_v[2] = flush_err && cr1;
    cand[2]   = '{kind: u2ls_pkg::KIND_UNIT, code_unit: u2ls_pkg::CH_CR, err: 1'b1};
    cand_v[3] = flush_err;
    cand[3]   = '{kind: u2ls_pkg::KIND_UNIT, code_unit: u2ls_pkg::REPL, err: 1'b1};
    cand_v[4] = final_b && cr2;
    cand[4]   = '{kind: u2ls_pkg::KIND_UNIT, code_unit: u2ls_pkg::CH_CR, err: e2};
    cand_v[5] = final_b && lo1;
    cand[5]   = '{kind: u2ls_pkg::KIND_EOL, code_unit: '0, err: e2};
  end

  // Pack valid candidates into the result group
  always_comb begin
    for (int s = 0; s < NSLOT; s++) begin
      grp[s] = '0;
    end
    grp_cnt = 2'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i] && (grp_cnt != 2'd3)) begin
        grp[grp_cnt] = cand[i];
        grp_cnt      = grp_cnt + 2'd1;
      end
    end
  end

  // Next decoder state: final byte returns everything to reset
  always_comb begin
    if (final_b) begin
      phase_next      = '0;
      partial_next    = '0;
      cr_held_next    = 1'b0;
      error_seen_next = 1'b0;
      line_open_next  = 1'b0;
    end else begin
      phase_next      = phase1;
      partial_next    = partial1;
      cr_held_next    = cr1;
      error_seen_next = e1;
      line_open_next  = lo1;
    end
  end

  // Advance decoder state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      partial    <= '0;
      cr_held    <= 1'b0;
      error_seen <= 1'b0;
      line_open  <= 1'b0;
    end else if (in_acc) begin
      phase      <= phase_next;
      partial    <= partial_next;
      cr_held    <= cr_held_next;
      error_seen <= error_seen_next;
      line_open  <= line_open_next;
    end
  end

  // Load a new group, or shift the held group by one per output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_acc) begin
      cnt <= grp_cnt;
    end else if (out_acc) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int s = 0; s < NSLOT; s++) begin
        slot[s] <= grp[s];
      end
    end else if (out_acc) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign units.valid           = (cnt != 2'd0);
  assign units.kind            = slot[0].kind;
  assign units.code_unit       = slot[0].code_unit;
  assign units.contains_errors = slot[0].err;
  assign units.last            = (cnt == 2'd1);

  `U2LS_ASSERT_NEXT(a_final_clears, in_acc && final_b,
    (phase == '0) && !cr_held && !error_seen && !line_open,
    "decoder state not cleared after final byte")
  `U2LS_ASSERT_IMPL(a_cr_in_line, cr_held, line_open,
    "CR held outside an open line")
  `U2LS_ASSERT_IMPL(a_seq_in_line, phase != '0, line_open,
    "multibyte sequence in progress outside an open line")
  `U2LS_ASSERT_NEXT(a_err_sticky, error_seen && !(in_acc && final_b), error_seen,
    "error flag dropped inside a stream")
  `U2LS_ASSERT_NEXT(a_group_hold, units.valid && !units.ready, units.valid
    && $stable(slot[0]), "result group changed while stalled")

endmodule
`default_nettype wire
